// ===== rtl/core/psfut_pkg.sv =====
// Package for the PSF Unicode table parser: constants, codes, controller types.
// No dependencies.
`timescale 1ns / 1ps
package psfut_pkg;

	localparam int unsigned MapEntriesDefault = 512;
	localparam logic [23:0] OffsetMax = 24'hFFFFFF;
	localparam logic [16:0] GlyphMax = 17'h1FFFF;
	localparam logic [15:0] Psf1Seq = 16'hFFFE;
	localparam logic [15:0] Psf1Sep = 16'hFFFF;
	localparam logic [7:0] Psf2Seq = 8'hFE;
	localparam logic [7:0] Psf2Sep = 8'hFF;
	localparam logic [20:0] SpaceCp = 21'h20;
	localparam logic [15:0] GlyphTotalReset = 16'd256;
	localparam logic [12:0] BytesPerGlyphReset = 13'd16;

	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_END = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_NOP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		REG_FORMAT = 2'd0,
		REG_HAS_TABLE = 2'd1,
		REG_GLYPH_TOTAL = 2'd2,
		REG_BPG = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SEARCH,
		ST_WAIT,
		ST_DONE
	} state_t;

	// decoded request handed from datapath to controller
	typedef struct packed {
		logic need_search;   // search the map for the item's codepoint (cp_q)
		logic insert;        // insert on miss
		logic end_space;     // end-of-table space insert: a hit is no redefinition
		logic lookup;        // result is a lookup
		logic identity;      // identity lookup: no search, only multiply
	} req_t;

	typedef struct packed {
		logic load;     // accept item, decode
		logic mul;      // register product
		logic clr_idx;  // reset search index
		logic step;     // read next entry
		logic finish;   // apply outcome, emit result
	} cmd_t;

	typedef struct packed {
		req_t req;
		logic hit;       // compare matched on current read data
		logic last;      // no more entries to read
	} sts_t;

endpackage

// ===== rtl/core/psfut_ctrl.sv =====
// Controller for the PSF Unicode table parser.
// Depends on psfut_pkg.
`timescale 1ns / 1ps
module psfut_ctrl
	import psfut_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.clr_idx = 1'b1;
				if (sts.req.need_search) state_d = ST_SEARCH;
				else state_d = ST_DONE;
			end
			ST_SEARCH: begin
				// issue read of current index, or stop when past fill
				if (sts.last) state_d = ST_DONE;
				else begin
					cmd.step = 1'b1;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (sts.hit) state_d = ST_DONE;
				else state_d = ST_SEARCH;
			end
			ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== rtl/core/psfut_dp.sv =====
// Datapath for the PSF Unicode table parser: byte decode, map memory,
// offset multiply and flag registers. Depends on psfut_pkg.
`timescale 1ns / 1ps
module psfut_dp
	import psfut_pkg::*;
#(
	parameter int unsigned MAP_ENTRIES = MapEntriesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  operation,
	input  logic [7:0]  table_byte,
	input  logic [20:0] lookup_codepoint,
	input  logic        cfg_valid,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        found,
	output logic [23:0] glyph_offset,
	output logic        table_stopped,
	output logic        invalid_utf_seen,
	output logic        redefinition_seen,
	output logic        sequence_seen,
	output logic        table_full,
	output logic        count_mismatch
);

	localparam int AW = $clog2(MAP_ENTRIES);

	logic        fmt_q, has_q;
	logic [15:0] gtot_q;
	logic [12:0] bpg_q;

	logic [20:0] mem_cp [MAP_ENTRIES];
	logic [23:0] mem_off [MAP_ENTRIES];
	logic [20:0] rd_cp_q;
	logic [23:0] rd_off_q;

	logic [AW:0]  fill_q;
	logic [AW:0]  idx_q;
	logic [16:0]  glyph_q;
	logic [31:0]  utf_q;
	logic [2:0]   ucnt_q;
	logic [8:0]   low_q;
	logic         f_stop_q, f_inv_q, f_redef_q, f_seq_q, f_full_q, f_mis_q;

	req_t         req_q;
	logic [20:0]  cp_q;
	logic [16:0]  mul_a_q;
	logic [23:0]  prod_q;
	logic         id_hit_q;
	logic         hit_q;

	function automatic logic [23:0] sat24(input logic [29:0] v);
		sat24 = (v > {6'd0, OffsetMax}) ? OffsetMax : v[23:0];
	endfunction

	// ---------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= 1'b0;
			has_q <= 1'b0;
			gtot_q <= GlyphTotalReset;
			bpg_q <= BytesPerGlyphReset;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FORMAT: fmt_q <= cfg_data[0];
				REG_HAS_TABLE: has_q <= cfg_data[0];
				REG_GLYPH_TOTAL: gtot_q <= cfg_data;
				REG_BPG: bpg_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// ---------------- byte decode (combinational, used on load)
	logic [15:0] p1_cp;
	logic [31:0] ub_new;
	logic [2:0]  uc_base, uc_new;
	logic [2:0]  ulen;
	logic [20:0] u_cp;
	logic        u_ok;
	logic [7:0]  lead, c1, c2, c3;

	assign p1_cp = {table_byte, low_q[7:0]};
	assign uc_base = (ucnt_q > 3'd3) ? 3'd0 : ucnt_q;
	assign uc_new = uc_base + 3'd1;

	always_comb begin
		ub_new = utf_q;
		unique case (uc_base[1:0])
			2'd0: ub_new[7:0] = table_byte;
			2'd1: ub_new[15:8] = table_byte;
			2'd2: ub_new[23:16] = table_byte;
			2'd3: ub_new[31:24] = table_byte;
			default: ;
		endcase
	end

	assign lead = ub_new[7:0];
	assign c1 = ub_new[15:8];
	assign c2 = ub_new[23:16];
	assign c3 = ub_new[31:24];

	always_comb begin
		priority if (!lead[7]) ulen = 3'd1;
		else if (lead[7:5] == 3'b110) ulen = 3'd2;
		else if (lead[7:4] == 4'b1110) ulen = 3'd3;
		else if (lead[7:3] == 5'b11110) ulen = 3'd4;
		else ulen = 3'd0;
	end

	always_comb begin
		u_cp = '0;
		u_ok = 1'b1;
		unique case (ulen)
			3'd2: begin
				u_cp = {10'd0, lead[4:0], c1[5:0]};
				u_ok = (c1[7:6] == 2'b10);
			end
			3'd3: begin
				u_cp = {5'd0, lead[3:0], c1[5:0], c2[5:0]};
				u_ok = (c1[7:6] == 2'b10) && (c2[7:6] == 2'b10);
			end
			3'd4: begin
				u_cp = {lead[2:0], c1[5:0], c2[5:0], c3[5:0]};
				u_ok = (c1[7:6] == 2'b10) && (c2[7:6] == 2'b10)
					&& (c3[7:6] == 2'b10);
			end
			default: u_cp = {14'd0, lead[6:0]};
		endcase
	end

	// ---------------- item decode: next state on load
	logic active;
	assign active = has_q && !f_stop_q;

	logic [16:0] glyph_inc;
	assign glyph_inc = (glyph_q < GlyphMax) ? glyph_q + 17'd1 : glyph_q;

	req_t        req_d;
	logic [20:0] cp_d;
	logic [16:0] mula_d;
	logic        idhit_d;
	logic [8:0]  low_d;
	logic [16:0] glyph_d;
	logic [31:0] utf_d;
	logic [2:0]  ucnt_d;
	logic        set_stop, set_inv, mis_d;

	always_comb begin
		req_d = '0;
		cp_d = lookup_codepoint;
		mula_d = glyph_q;
		idhit_d = 1'b0;
		low_d = low_q;
		glyph_d = glyph_q;
		utf_d = utf_q;
		ucnt_d = ucnt_q;
		set_stop = 1'b0;
		set_inv = 1'b0;
		mis_d = f_mis_q;
		unique case (op_t'(operation))
			OP_BYTE: begin
				if (active && !fmt_q) begin
					if (!low_q[8]) low_d = {1'b1, table_byte};
					else begin
						low_d = '0;
						if (p1_cp == Psf1Seq) set_stop = 1'b1;
						else if (p1_cp == Psf1Sep) glyph_d = glyph_inc;
						else begin
							cp_d = {5'd0, p1_cp};
							req_d.need_search = 1'b1;
							req_d.insert = 1'b1;
						end
					end
				end else if (active) begin
					if (table_byte == Psf2Seq) set_stop = 1'b1;
					else if (table_byte == Psf2Sep) begin
						if (ucnt_q != 3'd0) begin
							set_inv = 1'b1;
							ucnt_d = '0;
							utf_d = '0;
						end
						glyph_d = glyph_inc;
					end else if (ulen == 3'd0) begin
						set_inv = 1'b1;
						ucnt_d = '0;
						utf_d = '0;
					end else if (ulen != uc_new) begin
						utf_d = ub_new;
						ucnt_d = uc_new;
					end else begin
						ucnt_d = '0;
						utf_d = '0;
						if (u_ok) begin
							cp_d = u_cp;
							req_d.need_search = 1'b1;
							req_d.insert = 1'b1;
						end else set_inv = 1'b1;
					end
				end
			end
			OP_END: begin
				low_d = '0;
				ucnt_d = '0;
				utf_d = '0;
				if (has_q && !fmt_q) mis_d = ({1'b0, gtot_q} != glyph_q);
				else if (has_q) begin
					cp_d = SpaceCp;
					mula_d = {1'b0, gtot_q};
					req_d.need_search = 1'b1;
					req_d.insert = 1'b1;
					req_d.end_space = 1'b1;
				end
			end
			OP_LOOKUP: begin
				req_d.lookup = 1'b1;
				if (has_q) req_d.need_search = 1'b1;
				else begin
					req_d.identity = 1'b1;
					if (lookup_codepoint < {5'd0, gtot_q}) begin
						idhit_d = 1'b1;
						mula_d = lookup_codepoint[16:0];
					end else if (fmt_q && lookup_codepoint == SpaceCp) begin
						idhit_d = 1'b1;
						mula_d = {1'b0, gtot_q};
					end
				end
			end
			default: ;
		endcase
	end

	// ---------------- outcome on finish
	logic        ins_ok;
	logic        ins_fire;
	logic        redef_set, full_set;
	logic        found_d;
	logic [23:0] off_d;
	logic [AW-1:0] wr_addr;
	assign wr_addr = fill_q[AW-1:0];
	assign ins_ok = fill_q < (AW+1)'(MAP_ENTRIES);
	assign ins_fire = req_q.insert && !req_q.lookup && !hit_q && ins_ok;
	assign redef_set = req_q.insert && hit_q && !req_q.end_space;
	assign full_set = req_q.insert && !hit_q && !ins_ok;

	always_comb begin
		found_d = 1'b0;
		off_d = '0;
		if (req_q.lookup) begin
			if (req_q.identity) begin
				found_d = id_hit_q;
				off_d = id_hit_q ? prod_q : 24'd0;
			end else if (hit_q) begin
				found_d = 1'b1;
				off_d = rd_off_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			glyph_q <= '0;
			utf_q <= '0;
			ucnt_q <= '0;
			low_q <= '0;
			{f_stop_q, f_inv_q, f_redef_q, f_seq_q, f_full_q, f_mis_q} <= '0;
			req_q <= '0;
			cp_q <= '0;
			mul_a_q <= '0;
			prod_q <= '0;
			id_hit_q <= 1'b0;
			done <= 1'b0;
			found <= 1'b0;
			glyph_offset <= '0;
		end else begin
			done <= cmd.finish;
			if (cmd.load) begin
				req_q <= req_d;
				cp_q <= cp_d;
				mul_a_q <= mula_d;
				id_hit_q <= idhit_d;
				low_q <= low_d;
				glyph_q <= glyph_d;
				utf_q <= utf_d;
				ucnt_q <= ucnt_d;
				f_stop_q <= f_stop_q | set_stop;
				f_seq_q <= f_seq_q | set_stop;
				f_inv_q <= f_inv_q | set_inv;
				f_mis_q <= mis_d;
			end
			if (cmd.mul) prod_q <= sat24(30'(mul_a_q) * 30'(bpg_q));
			if (cmd.finish) begin
				found <= found_d;
				glyph_offset <= off_d;
				f_redef_q <= f_redef_q | redef_set;
				f_full_q <= f_full_q | full_set;
				if (ins_fire) fill_q <= fill_q + (AW+1)'(1);
			end
		end
	end

	// ---------------- map memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.finish && ins_fire) begin
			mem_cp[wr_addr] <= cp_q;
			mem_off[wr_addr] <= prod_q;
		end
		if (cmd.step) begin
			rd_cp_q <= mem_cp[idx_q[AW-1:0]];
			rd_off_q <= mem_off[idx_q[AW-1:0]];
		end
	end

	// ---------------- search index and hit
	logic match;
	assign match = (rd_cp_q == cp_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			hit_q <= 1'b0;
		end else begin
			if (cmd.clr_idx) begin
				idx_q <= '0;
				hit_q <= 1'b0;
			end else if (cmd.step) idx_q <= idx_q + (AW+1)'(1);
			else if (!cmd.finish && idx_q != '0 && match && !hit_q) hit_q <= 1'b1;
		end
	end

	assign sts.req = req_q;
	assign sts.hit = (idx_q != '0) && match;
	assign sts.last = (idx_q >= fill_q);

	assign table_stopped = f_stop_q;
	assign invalid_utf_seen = f_inv_q;
	assign redefinition_seen = f_redef_q;
	assign sequence_seen = f_seq_q;
	assign table_full = f_full_q;
	assign count_mismatch = f_mis_q;

endmodule

// ===== rtl/core/psf_unicode_table_parser.sv =====
// PSF Unicode table parser: builds a codepoint to glyph-offset map from table
// bytes and answers lookups. Depends on psfut_pkg, psfut_ctrl, psfut_dp.
// Steps: start loads the item, MUL registers the offset product, then SEARCH
// and WAIT read stored entries up to map fill (insert and table lookup), and
// DONE raises the strobe. One item at a time; busy stays high until the strobe.
// Reset: arst_n clears control, fill count and flags; map contents are not
// cleared, the fill count bounds every search. The receiver cannot stall.
`timescale 1ns / 1ps
module psf_unicode_table_parser
	import psfut_pkg::*;
#(
	parameter int unsigned MAP_ENTRIES = MapEntriesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  operation,
	input  logic [7:0]  table_byte,
	input  logic [20:0] lookup_codepoint,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        done,
	output logic        found,
	output logic [23:0] glyph_offset,
	output logic        table_stopped,
	output logic        invalid_utf_seen,
	output logic        redefinition_seen,
	output logic        sequence_seen,
	output logic        table_full,
	output logic        count_mismatch
);

	cmd_t cmd;
	sts_t sts;

	// registers are always writable; the user must write them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	psfut_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sts(sts), .cmd(cmd)
	);

	psfut_dp #(.MAP_ENTRIES(MAP_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.operation(operation), .table_byte(table_byte),
		.lookup_codepoint(lookup_codepoint),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .found(found), .glyph_offset(glyph_offset),
		.table_stopped(table_stopped), .invalid_utf_seen(invalid_utf_seen),
		.redefinition_seen(redefinition_seen), .sequence_seen(sequence_seen),
		.table_full(table_full), .count_mismatch(count_mismatch)
	);

endmodule

// ===== rtl/core/psfut_checker.sv =====
// Port-level checker for the PSF Unicode table parser, with its bind.
// Depends on psf_unicode_table_parser ports only.
`timescale 1ns / 1ps
module psfut_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic found,
	input logic [23:0] glyph_offset,
	input logic table_stopped,
	input logic sequence_seen
);

	// a transaction accepted always raises busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised");

	// the done strobe is never asserted back to back
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$past(done)) else $error("double strobe");

	// a miss reports zero offset
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		done && !found |-> glyph_offset == 24'd0) else $error("miss offset");

	// stop and sequence flags travel together
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		table_stopped == sequence_seen) else $error("flag pair split");

endmodule

bind psf_unicode_table_parser psfut_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.found(found), .glyph_offset(glyph_offset), .table_stopped(table_stopped),
	.sequence_seen(sequence_seen)
);
